[sv/cwdm_pkg.sv]
// Shared types and constants for the cluster-weighted distance matrix block.
package cwdm_pkg;

	localparam int VALUE_W = 24;
	localparam int SIZE_W  = 8;
	localparam int FIELD_W = 3;
	localparam int CC_W    = 4;
	localparam int MAG_W   = 24;
	localparam int SQ_W    = 48;
	localparam int PROD_W  = 56;
	localparam int DIST_W  = 59;

	localparam logic [CC_W-1:0] CLUSTER_COUNT_RST = 4'd8;

	typedef enum logic [1:0] {
		OP_LOAD_ENTRY = 2'd0,
		OP_LOAD_SIZE  = 2'd1,
		OP_COMPUTE    = 2'd2
	} op_t;

	typedef struct packed {
		logic issue;
		logic first;
		logic tail;
		logic self;
	} mac_ctl_t;

endpackage

[sv/cwdm_store.sv]
// Reduced matrix memory with two registered read ports and the cluster size table.
module cwdm_store #(
	parameter int MAX_CLUSTERS = 8,
	parameter int IW = $clog2(MAX_CLUSTERS),
	parameter int AW = 2 * IW
) (
	input  logic                           clk,
	input  logic                           mat_we,
	input  logic [AW-1:0]                  mat_waddr,
	input  logic [cwdm_pkg::VALUE_W-1:0]   mat_wdata,
	input  logic                           size_we,
	input  logic [IW-1:0]                  size_waddr,
	input  logic [cwdm_pkg::SIZE_W-1:0]    size_wdata,
	input  logic [AW-1:0]                  addr_a,
	input  logic [AW-1:0]                  addr_b,
	input  logic [IW-1:0]                  size_raddr,
	output logic [cwdm_pkg::VALUE_W-1:0]   rd_a,
	output logic [cwdm_pkg::VALUE_W-1:0]   rd_b,
	output logic [cwdm_pkg::SIZE_W-1:0]    rd_size
);
	import cwdm_pkg::*;

	localparam int DEPTH = 1 << AW;

	logic [VALUE_W-1:0] mat_mem [DEPTH];
	logic [SIZE_W-1:0]  size_mem [MAX_CLUSTERS];

	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[mat_waddr] <= mat_wdata;
		end
		rd_a <= mat_mem[addr_a];
		rd_b <= mat_mem[addr_b];
	end

	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[size_waddr] <= size_wdata;
		end
		rd_size <= size_mem[size_raddr];
	end

endmodule

[sv/cwdm_mac.sv]
// Shared difference, square, weight and accumulate pipeline.
module cwdm_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cwdm_pkg::mac_ctl_t            ctl,
	input  logic [cwdm_pkg::VALUE_W-1:0]  rd_a,
	input  logic [cwdm_pkg::VALUE_W-1:0]  rd_b,
	input  logic [cwdm_pkg::SIZE_W-1:0]   rd_size,
	output logic                          done,
	output logic [cwdm_pkg::DIST_W-1:0]   acc
);
	import cwdm_pkg::*;

	mac_ctl_t            ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [MAG_W-1:0]    mag_s2;
	logic [SIZE_W-1:0]   w_s2, w_s3;
	logic [SQ_W-1:0]     sq_s3;
	logic [PROD_W-1:0]   prod_s4;
	logic [DIST_W-1:0]   acc_q;
	logic                done_q;

	logic signed [VALUE_W:0] diff;
	logic [MAG_W-1:0]        mag;
	logic [SIZE_W-1:0]       weight;

	always_comb begin
		diff = $signed({rd_a[VALUE_W-1], rd_a}) - $signed({rd_b[VALUE_W-1], rd_b});
		mag = diff[VALUE_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
		weight = rd_size - SIZE_W'(ctl_s1.self && (rd_size != '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			done_q <= ctl_s4.issue && ctl_s4.tail;
		end
	end

	always_ff @(posedge clk) begin
		mag_s2  <= mag;
		w_s2    <= weight;
		sq_s3   <= SQ_W'(mag_s2) * SQ_W'(mag_s2);
		w_s3    <= w_s2;
		prod_s4 <= PROD_W'(w_s3) * PROD_W'(sq_s3);
		if (ctl_s4.issue) begin
			acc_q <= ctl_s4.first ? DIST_W'(prod_s4) : acc_q + DIST_W'(prod_s4);
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

[sv/cluster_weighted_distance_matrix.sv]
// Top level: item decode, pair sequencer and output register of the distance matrix block.
//
// Usage: the input channel (in_valid, in_stall) carries one item per beat. A load entry
// item writes one reduced matrix entry and a load size item writes one cluster size, and
// neither gives a result. A compute item emits the K by K weighted squared
// distance matrix on the output channel (out_valid, out_stall), row by row, one entry per
// beat, with last set on the final entry.
// For each entry the sequencer issues one column per cycle through the shared
// subtract, square, weight and accumulate pipeline, waits for the accumulation to finish
// and hands the sum to the output register before starting the next pair. in_stall stays
// high for the whole compute item.
// The cluster count register is written over its own channel (cfg_valid, cfg_ready); the
// user must write it only while the block is idle, and the block itself leaves this to the
// user. Values of zero act as one and values above MAX_CLUSTERS act as MAX_CLUSTERS.
// When the receiver stalls, the finished entry waits in the output register and the
// sequencer holds before starting the next pair.
// Reset clears the control state and sets the cluster count to eight. The matrix and
// size storage hold no defined value until written.
module cluster_weighted_distance_matrix #(
	parameter int MAX_CLUSTERS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cwdm_pkg::CC_W-1:0]      cluster_count,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     operation,
	input  logic [cwdm_pkg::FIELD_W-1:0]   row,
	input  logic [cwdm_pkg::FIELD_W-1:0]   col,
	input  logic [cwdm_pkg::VALUE_W-1:0]   value,
	input  logic [cwdm_pkg::SIZE_W-1:0]    cluster_size,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [cwdm_pkg::FIELD_W-1:0]   row_index,
	output logic [cwdm_pkg::FIELD_W-1:0]   col_index,
	output logic [cwdm_pkg::DIST_W-1:0]    distance,
	output logic                           last
);
	import cwdm_pkg::*;

	localparam int IW = $clog2(MAX_CLUSTERS);
	localparam int AW = 2 * IW;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CC_W-1:0]    cluster_count_q;
	logic [IW-1:0]      k_q, l_q, j_q, last_idx_q;
	logic [IW-1:0]      kk_last;
	logic               out_valid_q;
	logic [FIELD_W-1:0] row_index_q, col_index_q;
	logic [DIST_W-1:0]  distance_q;
	logic               last_q;

	logic               in_accept;
	logic               in_range_row, in_range_col;
	logic               mat_we, size_we;
	logic               emit_load, pair_last;
	mac_ctl_t           ctl;
	logic [VALUE_W-1:0] rd_a, rd_b;
	logic [SIZE_W-1:0]  rd_size;
	logic               mac_done;
	logic [DIST_W-1:0]  mac_acc;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign in_range_row = int'(row) < MAX_CLUSTERS;
	assign in_range_col = int'(col) < MAX_CLUSTERS;
	assign mat_we  = in_accept && (operation == OP_LOAD_ENTRY) && in_range_row && in_range_col;
	assign size_we = in_accept && (operation == OP_LOAD_SIZE) && in_range_row;

	always_comb begin
		if (cluster_count_q == '0) begin
			kk_last = '0;
		end else if (int'(cluster_count_q) > MAX_CLUSTERS) begin
			kk_last = IW'(MAX_CLUSTERS - 1);
		end else begin
			kk_last = IW'(cluster_count_q - CC_W'(1));
		end
	end

	assign pair_last = (k_q == last_idx_q) && (l_q == last_idx_q);
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		ctl.issue = (state_q == ST_RUN);
		ctl.first = (j_q == '0);
		ctl.tail  = (j_q == last_idx_q);
		ctl.self  = (j_q == k_q) || (j_q == l_q);
	end

	cwdm_store #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.IW(IW),
		.AW(AW)
	) u_store (
		.clk       (clk),
		.mat_we    (mat_we),
		.mat_waddr ({row[IW-1:0], col[IW-1:0]}),
		.mat_wdata (value),
		.size_we   (size_we),
		.size_waddr(row[IW-1:0]),
		.size_wdata(cluster_size),
		.addr_a    ({k_q, j_q}),
		.addr_b    ({l_q, j_q}),
		.size_raddr(j_q),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.rd_size   (rd_size)
	);

	cwdm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rd_a   (rd_a),
		.rd_b   (rd_b),
		.rd_size(rd_size),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cluster_count_q <= CLUSTER_COUNT_RST;
			k_q             <= '0;
			l_q             <= '0;
			j_q             <= '0;
			last_idx_q      <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cluster_count_q <= cluster_count;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (operation == OP_COMPUTE)) begin
						last_idx_q <= kk_last;
						k_q        <= '0;
						l_q        <= '0;
						j_q        <= '0;
						state_q    <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (j_q == last_idx_q) begin
						state_q <= ST_WAIT;
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				ST_WAIT: begin
					if (mac_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						j_q <= '0;
						if (pair_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RUN;
							if (l_q == last_idx_q) begin
								l_q <= '0;
								k_q <= k_q + IW'(1);
							end else begin
								l_q <= l_q + IW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			row_index_q <= FIELD_W'(k_q);
			col_index_q <= FIELD_W'(l_q);
			distance_q  <= mac_acc;
			last_q      <= pair_last;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = row_index_q;
	assign col_index = col_index_q;
	assign distance  = distance_q;
	assign last      = last_q;

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("Output beat appeared without an emit step.");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_WAIT))
		else $error("Accumulator finished outside the wait step.");

	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (row_index_q == col_index_q))
		else $error("Final beat is not on the diagonal.");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (j_q <= last_idx_q))
		else $error("Column counter ran past the cluster count.");

endmodule
